// File: design/wavhp_pkg.sv
// Package for the WAV header parser: phases, codes, queue and result word types.
`default_nettype none
package wavhp_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_RIFF   = 4'd1,
    PH_RSIZE  = 4'd2,
    PH_WAVE   = 4'd3,
    PH_FMT    = 4'd4,
    PH_FSIZE  = 4'd5,
    PH_FBLOCK = 4'd6,
    PH_CID    = 4'd7,
    PH_CSIZE  = 4'd8,
    PH_SKIP   = 4'd9,
    PH_DATA   = 4'd10
  } phase_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_RIFF     = 3'd1;
  localparam logic [2:0] ERR_WAVE     = 3'd2;
  localparam logic [2:0] ERR_FMT      = 3'd3;
  localparam logic [2:0] ERR_BITS     = 3'd4;
  localparam logic [2:0] ERR_CHANNELS = 3'd5;

  localparam logic [1:0] TAG_RIFF = 2'd0;
  localparam logic [1:0] TAG_WAVE = 2'd1;
  localparam logic [1:0] TAG_FMT  = 2'd2;
  localparam logic [1:0] TAG_DATA = 2'd3;

  // Four chunk tags, four characters each, in stream order.
  localparam logic [7:0] TAG_BYTES [4][4] = '{
    '{8'h52, 8'h49, 8'h46, 8'h46},
    '{8'h57, 8'h41, 8'h56, 8'h45},
    '{8'h66, 8'h6d, 8'h74, 8'h20},
    '{8'h64, 8'h61, 8'h74, 8'h61}
  };

  // One queued word: the byte, its restart mark and its tag matches.
  // match[{tag, position}] is set when the byte equals that tag character.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start;
    logic [15:0] match;
  } queue_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [2:0]  sample_format;
    logic [31:0] data_bytes;
    logic [2:0]  error_code;
    logic        not_pcm;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

// File: design/wavhp_ifs.sv
// Valid/ready channel interfaces for the byte input and the result output.
`default_nettype none
interface wavhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_file;
  modport source (output valid, output in_byte, output start_file, input ready);
  modport sink   (input valid, input in_byte, input start_file, output ready);
endinterface

interface wavhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [15:0] sample_bits;
  logic [2:0]  sample_format;
  logic [31:0] data_bytes;
  logic [2:0]  error_code;
  logic        not_pcm;
  logic        last;
  modport source (output valid, output kind, output payload_byte, output channel_count,
                  output sample_rate, output sample_bits, output sample_format,
                  output data_bytes, output error_code, output not_pcm, output last,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte, input channel_count,
                  input sample_rate, input sample_bits, input sample_format,
                  input data_bytes, input error_code, input not_pcm, input last,
                  output ready);
endinterface
`default_nettype wire

// File: design/wavhp_front.sv
// Front end: tags each incoming byte against the chunk tags and queues it.
`default_nettype none
module wavhp_front #(
  parameter int DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_byte,
  input  wire logic                  in_start,
  output logic                       q_valid,
  output wavhp_pkg::queue_item_t     q_item,
  input  wire logic                  q_pop,
  output logic [$clog2(DEPTH+1)-1:0] q_count
);
  import wavhp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  queue_item_t       mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic              push;
  queue_item_t       new_item;

  always_comb begin
    new_item.data_byte = in_byte;
    new_item.start     = in_start;
    for (int t = 0; t < 4; t++) begin
      for (int i = 0; i < 4; i++) begin
        new_item.match[t*4 + i] = (in_byte == TAG_BYTES[t][i]);
      end
    end
  end

  assign in_ready = (count_r != CW'(DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign q_count  = count_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && q_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Pointers wrap at the last entry, so any depth works.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule
`default_nettype wire

// File: design/wavhp_back.sv
// Back end: the parsing state machine and the registered result slot.
`default_nettype none
module wavhp_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  input  wire wavhp_pkg::queue_item_t q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output wavhp_pkg::result_t          out_res
);
  import wavhp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] fs_r, fs_nxt;
  logic        chm_r, chm_nxt;
  logic [15:0] ch_r, ch_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [15:0] fcode_r, fcode_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [31:0] drem_r, drem_nxt;
  logic        out_valid_r;
  result_t     out_res_r;

  phase_t      ph;
  logic [3:0]  idx;
  logic [31:0] fs;
  logic        chm;
  logic [15:0] ch;
  logic [31:0] rate;
  logic [15:0] bits;
  logic [15:0] fcode;
  logic [31:0] skip;
  logic [31:0] drem;
  logic [7:0]  b;
  logic [1:0]  tag_sel;
  logic [2:0]  tag_err;
  phase_t      tag_next;
  logic        tag_hit;
  logic [31:0] size;
  logic [2:0]  base;
  logic [2:0]  cls_fmt;
  logic [2:0]  cls_err;
  logic        emit;
  result_t     res;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    ph    = phase_r;
    idx   = idx_r;
    fs    = fs_r;
    chm   = chm_r;
    ch    = ch_r;
    rate  = rate_r;
    bits  = bits_r;
    fcode = fcode_r;
    skip  = skip_r;
    drem  = drem_r;
    b     = q_item.data_byte;
    if (q_item.start) begin
      ph    = PH_RIFF;
      idx   = '0;
      fs    = '0;
      chm   = 1'b0;
      ch    = '0;
      rate  = '0;
      bits  = '0;
      fcode = '0;
      skip  = '0;
      drem  = '0;
    end

    case (ph)
      PH_RIFF: begin
        tag_sel = TAG_RIFF; tag_err = ERR_RIFF; tag_next = PH_RSIZE;
      end
      PH_WAVE: begin
        tag_sel = TAG_WAVE; tag_err = ERR_WAVE; tag_next = PH_FMT;
      end
      default: begin
        tag_sel = TAG_FMT; tag_err = ERR_FMT; tag_next = PH_FSIZE;
      end
    endcase
    tag_hit = q_item.match[{tag_sel, idx[1:0]}];

    // Little-endian gather of the size word, with this byte in its lane.
    size = fs | (32'(b) << {idx[1:0], 3'b000});

    case (bits)
      16'd8:   begin base = 3'd0; cls_err = ERR_NONE; end
      16'd16:  begin base = 3'd2; cls_err = ERR_NONE; end
      16'd32:  begin base = 3'd4; cls_err = ERR_NONE; end
      16'd64:  begin base = 3'd6; cls_err = ERR_NONE; end
      default: begin base = 3'd0; cls_err = ERR_BITS; end
    endcase
    cls_fmt = 3'd0;
    if (cls_err == ERR_NONE) begin
      if (ch == 16'd1) begin
        cls_fmt = base;
      end else if (ch == 16'd2) begin
        cls_fmt = base + 3'd1;
      end else begin
        cls_err = ERR_CHANNELS;
      end
    end

    phase_nxt = ph;
    idx_nxt   = idx;
    fs_nxt    = fs;
    chm_nxt   = chm;
    ch_nxt    = ch;
    rate_nxt  = rate;
    bits_nxt  = bits;
    fcode_nxt = fcode;
    skip_nxt  = skip;
    drem_nxt  = drem;
    emit      = 1'b0;
    res       = '0;

    case (ph)
      PH_RIFF, PH_WAVE, PH_FMT: begin
        if (!tag_hit) begin
          emit           = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = tag_err;
          res.last       = 1'b1;
          phase_nxt      = PH_IDLE;
        end else if (idx[1:0] == 2'd3) begin
          idx_nxt   = '0;
          phase_nxt = tag_next;
        end else begin
          idx_nxt = idx + 4'd1;
        end
      end
      PH_RSIZE, PH_FSIZE: begin
        // The RIFF size and the format size are not used.
        if (idx[1:0] == 2'd3) begin
          idx_nxt   = '0;
          fs_nxt    = '0;
          phase_nxt = (ph == PH_RSIZE) ? PH_WAVE : PH_FBLOCK;
        end else begin
          idx_nxt = idx + 4'd1;
        end
      end
      PH_FBLOCK: begin
        // Each lane is written once per file after the fields were cleared.
        case (idx)
          4'd0:    fcode_nxt[7:0]   = b;
          4'd1:    fcode_nxt[15:8]  = b;
          4'd2:    ch_nxt[7:0]      = b;
          4'd3:    ch_nxt[15:8]     = b;
          4'd4:    rate_nxt[7:0]    = b;
          4'd5:    rate_nxt[15:8]   = b;
          4'd6:    rate_nxt[23:16]  = b;
          4'd7:    rate_nxt[31:24]  = b;
          4'd14:   bits_nxt[7:0]    = b;
          4'd15:   bits_nxt[15:8]   = b;
          default: ;
        endcase
        if (idx == 4'd15) begin
          idx_nxt   = '0;
          phase_nxt = PH_CID;
        end else begin
          idx_nxt = idx + 4'd1;
        end
      end
      PH_CID: begin
        chm_nxt = ((idx[1:0] == 2'd0) ? 1'b1 : chm) && q_item.match[{TAG_DATA, idx[1:0]}];
        if (idx[1:0] == 2'd3) begin
          idx_nxt   = '0;
          fs_nxt    = '0;
          phase_nxt = PH_CSIZE;
        end else begin
          idx_nxt = idx + 4'd1;
        end
      end
      PH_CSIZE: begin
        if (idx[1:0] != 2'd3) begin
          fs_nxt  = size;
          idx_nxt = idx + 4'd1;
        end else begin
          idx_nxt = '0;
          fs_nxt  = '0;
          if (chm) begin
            emit              = 1'b1;
            res.channel_count = ch;
            res.sample_rate   = rate;
            res.sample_bits   = bits;
            res.data_bytes    = size;
            res.not_pcm       = (fcode != 16'd1);
            if (cls_err != ERR_NONE) begin
              res.kind       = KIND_ERROR;
              res.error_code = cls_err;
              res.last       = 1'b1;
              phase_nxt      = PH_IDLE;
            end else begin
              res.kind          = KIND_HEADER;
              res.sample_format = cls_fmt;
              res.last          = (size == '0);
              drem_nxt          = size;
              phase_nxt         = (size != '0) ? PH_DATA : PH_IDLE;
            end
          end else begin
            skip_nxt  = size;
            phase_nxt = (size != '0) ? PH_SKIP : PH_CID;
          end
        end
      end
      PH_SKIP: begin
        if (skip != '0) begin
          skip_nxt = skip - 32'd1;
        end
        if (skip_nxt == '0) begin
          idx_nxt   = '0;
          phase_nxt = PH_CID;
        end
      end
      PH_DATA: begin
        emit             = 1'b1;
        res.kind         = KIND_DATA;
        res.payload_byte = b;
        res.last         = (drem <= 32'd1);
        if (drem != '0) begin
          drem_nxt = drem - 32'd1;
        end
        if (drem_nxt == '0) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      phase_r     <= phase_nxt;
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      idx_r   <= idx_nxt;
      fs_r    <= fs_nxt;
      chm_r   <= chm_nxt;
      ch_r    <= ch_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
      fcode_r <= fcode_nxt;
      skip_r  <= skip_nxt;
      drem_r  <= drem_nxt;
      if (emit) begin
        out_res_r <= res;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/wav_header_parser.sv
// Top level of the WAV header parser: front queue, parser back end, checks.
//
// in_ch carries one file byte per word plus start_file, which marks byte 0
// of a new file and restarts parsing wherever the parser stands. out_ch
// carries result words: a header word (or an error word) once the data
// chunk size is complete, then one word per data byte, the final one with
// last set. Tag errors come on the first mismatching byte.
// Each accepted byte is tagged and written into a small queue (QUEUE_DEPTH
// words); the parser takes one byte per cycle from it while the output
// register is free or being taken, and fills that single output register.
// A byte passes the queue, then the parser step, which registers its
// result word; with out_ch ready the sustained rate is one byte per cycle.
// When out_ch stalls, the parser holds its result and waits; the queue
// keeps accepting until it is full, then in_ch.ready drops.
// Bytes that arrive without start_file while the parser is idle produce no
// result. After reset the parser is idle and the queue and output are empty.
`default_nettype none
module wav_header_parser #(
  parameter int QUEUE_DEPTH = wavhp_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  wavhp_in_if.sink   in_ch,
  wavhp_out_if.source out_ch
);
  import wavhp_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          q_valid;
  logic          q_pop;
  queue_item_t   q_item;
  logic [CW-1:0] q_count;
  logic          in_ready;
  logic          out_valid;
  result_t       out_res;

  wavhp_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .in_byte  (in_ch.in_byte),
    .in_start (in_ch.start_file),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .q_count  (q_count)
  );

  wavhp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.kind          = out_res.kind;
  assign out_ch.payload_byte  = out_res.payload_byte;
  assign out_ch.channel_count = out_res.channel_count;
  assign out_ch.sample_rate   = out_res.sample_rate;
  assign out_ch.sample_bits   = out_res.sample_bits;
  assign out_ch.sample_format = out_res.sample_format;
  assign out_ch.data_bytes    = out_res.data_bytes;
  assign out_ch.error_code    = out_res.error_code;
  assign out_ch.not_pcm       = out_res.not_pcm;
  assign out_ch.last          = out_res.last;

  // The queue never holds more words than it has room for.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // A byte accepted into an empty queue is offered to the parser next cycle.
  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready && !q_valid) |=> q_valid)
    else $error("accepted byte lost in queue");

  // The parser only takes a byte while the output slot is free or draining.
  a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && (!out_valid || out_ch.ready)))
    else $error("parser step while result slot blocked");

  // A stalled result is never overwritten.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ch.ready) |=> (out_valid && $stable(out_res)))
    else $error("stalled result changed");

endmodule
`default_nettype wire

// File: tb/sv/wavhp_tb_pkg.sv
// Scoreboard for the WAV header parser: byte-level parser model and result checks.
`timescale 1ns / 1ps
package wavhp_tb_pkg;
  import wavhp_pkg::*;

  class wav_scoreboard;
    result_t     awaited_results[$];
    int unsigned error_count;

    // Parser state as the stream has moved it so far.
    phase_t      stage;
    logic [5:0]  pos;
    logic [31:0] word_acc;
    bit          id_is_data;
    logic [15:0] chans;
    logic [31:0] rate_hz;
    logic [15:0] depth_bits;
    logic [15:0] fmt_code;
    logic [31:0] skip_left;
    logic [31:0] data_left;

    function new();
      error_count = 0;
      stage = PH_IDLE;
      clear_file();
    endfunction

    function void clear_file();
      pos = '0;
      word_acc = '0;
      id_is_data = 0;
      chans = '0;
      rate_hz = '0;
      depth_bits = '0;
      fmt_code = '0;
      skip_left = '0;
      data_left = '0;
    endfunction

    function bit check_tag(logic [7:0] b, logic [1:0] tag, logic [2:0] err, phase_t nxt,
                           output result_t r);
      r = '0;
      if (b != TAG_BYTES[tag][pos[1:0]]) begin
        r.kind = KIND_ERROR;
        r.error_code = err;
        r.last = 1'b1;
        stage = PH_IDLE;
        return 1;
      end
      if (pos >= 6'd3) begin
        pos = '0;
        stage = nxt;
      end else begin
        pos++;
      end
      return 0;
    endfunction

    // Little-endian word assembly; true once the fourth byte is in.
    function bit gather(logic [7:0] b);
      word_acc |= 32'(b) << (8 * pos[1:0]);
      if (pos >= 6'd3) begin
        pos = '0;
        return 1;
      end
      pos++;
      return 0;
    endfunction

    function void classify(output logic [2:0] fmt, output logic [2:0] err);
      logic [2:0] base;
      fmt = 3'd0;
      err = ERR_NONE;
      case (depth_bits)
        16'd8: base = 3'd0;
        16'd16: base = 3'd2;
        16'd32: base = 3'd4;
        16'd64: base = 3'd6;
        default: begin
          err = ERR_BITS;
          return;
        end
      endcase
      if (chans == 16'd1) fmt = base;
      else if (chans == 16'd2) fmt = base + 3'd1;
      else err = ERR_CHANNELS;
    endfunction

    function bit parse_byte(logic [7:0] b, bit st, output result_t r);
      int unsigned idx;
      logic [2:0]  fmt;
      logic [2:0]  err;
      bit          emitted;
      r = '0;
      emitted = 0;
      if (st) begin
        clear_file();
        stage = PH_RIFF;
      end
      case (stage)
        PH_RIFF: emitted = check_tag(b, TAG_RIFF, ERR_RIFF, PH_RSIZE, r);
        PH_RSIZE: begin
          if (gather(b)) begin
            word_acc = '0;
            stage = PH_WAVE;
          end
        end
        PH_WAVE: emitted = check_tag(b, TAG_WAVE, ERR_WAVE, PH_FMT, r);
        PH_FMT: emitted = check_tag(b, TAG_FMT, ERR_FMT, PH_FSIZE, r);
        PH_FSIZE: begin
          if (gather(b)) begin
            word_acc = '0;
            stage = PH_FBLOCK;
          end
        end
        PH_FBLOCK: begin
          idx = pos;
          if (idx < 2) fmt_code |= 16'(16'(b) << (8 * idx));
          else if (idx < 4) chans |= 16'(16'(b) << (8 * (idx - 2)));
          else if (idx < 8) rate_hz |= 32'(b) << (8 * (idx - 4));
          else if (idx >= 14 && idx < 16) depth_bits |= 16'(16'(b) << (8 * (idx - 14)));
          if (idx >= 15) begin
            pos = '0;
            stage = PH_CID;
          end else begin
            pos++;
          end
        end
        PH_CID: begin
          if (pos[1:0] == 2'd0) id_is_data = 1;
          if (b != TAG_BYTES[TAG_DATA][pos[1:0]]) id_is_data = 0;
          if (pos[1:0] == 2'd3) begin
            pos = '0;
            word_acc = '0;
            stage = PH_CSIZE;
          end else begin
            pos++;
          end
        end
        PH_CSIZE: begin
          if (gather(b)) begin
            if (id_is_data) begin
              classify(fmt, err);
              r.channel_count = chans;
              r.sample_rate = rate_hz;
              r.sample_bits = depth_bits;
              r.data_bytes = word_acc;
              r.not_pcm = (fmt_code != 16'd1);
              r.last = 1'b1;
              if (err != ERR_NONE) begin
                r.kind = KIND_ERROR;
                r.error_code = err;
                stage = PH_IDLE;
              end else begin
                r.kind = KIND_HEADER;
                r.sample_format = fmt;
                r.last = (word_acc == 32'd0);
                data_left = word_acc;
                stage = (word_acc != 32'd0) ? PH_DATA : PH_IDLE;
              end
              word_acc = '0;
              emitted = 1;
            end else begin
              skip_left = word_acc;
              word_acc = '0;
              stage = (skip_left != 32'd0) ? PH_SKIP : PH_CID;
            end
          end
        end
        PH_SKIP: begin
          if (skip_left > 0) skip_left--;
          if (skip_left == 0) begin
            pos = '0;
            stage = PH_CID;
          end
        end
        PH_DATA: begin
          r.kind = KIND_DATA;
          r.payload_byte = b;
          r.last = (data_left <= 32'd1);
          if (data_left > 0) data_left--;
          if (data_left == 0) stage = PH_IDLE;
          emitted = 1;
        end
        default: stage = PH_IDLE;
      endcase
      return emitted;
    endfunction

    // Notes one accepted byte; returns 1 when the parser did not simply ignore it.
    function bit note_byte(logic [7:0] b, bit st);
      result_t r;
      bit      live;
      live = st || (stage != PH_IDLE);
      if (parse_byte(b, st, r)) awaited_results.push_back(r);
      return live;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    function void match_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        error_count++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        $error("unexpected result word: kind %0d payload 0x%0h", got.kind, got.payload_byte);
        error_count++;
        return;
      end
      want = awaited_results.pop_front();
      match_field("kind", want.kind, got.kind);
      match_field("payload_byte", want.payload_byte, got.payload_byte);
      match_field("channel_count", want.channel_count, got.channel_count);
      match_field("sample_rate", want.sample_rate, got.sample_rate);
      match_field("sample_bits", want.sample_bits, got.sample_bits);
      match_field("sample_format", want.sample_format, got.sample_format);
      match_field("data_bytes", want.data_bytes, got.data_bytes);
      match_field("error_code", want.error_code, got.error_code);
      match_field("not_pcm", want.not_pcm, got.not_pcm);
      match_field("last", want.last, got.last);
    endfunction
  endclass

endpackage

// File: tb/sv/tb_top.sv
// Top-level testbench for the WAV header parser: stimulus, handshakes and final verdict.
`timescale 1ns / 1ps
module tb_top;
  import wavhp_pkg::*;
  import wavhp_tb_pkg::*;

  localparam int unsigned ITEM_TARGET = 1900;

  logic clk;
  logic rst_n;

  wavhp_in_if  in_ch ();
  wavhp_out_if out_ch ();

  wav_header_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  wav_scoreboard sb;
  logic [7:0]    wav_q[$];
  int unsigned   sent_count = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Offers one byte and returns at the edge where it is accepted.
  task automatic send_byte(input logic [7:0] b, input bit st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.start_file <= st;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    void'(sb.note_byte(b, st));
    sent_count++;
  endtask

  task automatic push_le(input logic [31:0] w, input int unsigned nbytes);
    for (int i = 0; i < nbytes; i++) wav_q.push_back(w[8*i +: 8]);
  endtask

  task automatic push_tag(input logic [1:0] tag);
    for (int i = 0; i < 4; i++) wav_q.push_back(TAG_BYTES[tag][i]);
  endtask

  // Starts a new file image: tags, sizes and the 16-byte format block.
  task automatic begin_file(input logic [15:0] code, input logic [15:0] ch,
                            input logic [31:0] rate, input logic [15:0] depth);
    wav_q.delete();
    push_tag(TAG_RIFF);
    push_le($urandom, 4);
    push_tag(TAG_WAVE);
    push_tag(TAG_FMT);
    push_le($urandom, 4);
    push_le(code, 2);
    push_le(ch, 2);
    push_le(rate, 4);
    push_le($urandom, 4);
    push_le($urandom, 2);
    push_le(depth, 2);
  endtask

  // Chunk id is written first character first; count bytes of body follow.
  task automatic add_chunk(input logic [31:0] id, input logic [31:0] size,
                           input int unsigned count);
    for (int i = 3; i >= 0; i--) wav_q.push_back(id[8*i +: 8]);
    push_le(size, 4);
    repeat (count) wav_q.push_back(8'($urandom));
  endtask

  task automatic send_file();
    foreach (wav_q[k]) send_byte(wav_q[k], k == 0);
  endtask

  task automatic random_file();
    int unsigned pick;
    int unsigned n;
    logic [15:0] ch;
    logic [15:0] depth;
    logic [15:0] code;
    pick = $urandom_range(99);
    if (pick < 6) begin
      // Stray bytes, now and then with a restart mark among them.
      repeat ($urandom_range(8, 1)) send_byte(8'($urandom), $urandom_range(9) == 0);
      return;
    end
    ch = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(2, 1));
    depth = ($urandom_range(9) == 0) ? 16'($urandom_range(72)) : 16'(8 << $urandom_range(3));
    code = ($urandom_range(4) == 0) ? 16'($urandom) : 16'd1;
    begin_file(code, ch, $urandom, depth);
    repeat ($urandom_range(2)) begin
      n = $urandom_range(6);
      add_chunk($urandom, n, n);
    end
    n = $urandom_range(20);
    add_chunk("data", n, n);
    if (pick < 14) begin
      wav_q[$urandom_range(15)] = 8'($urandom);
    end else if (pick < 22) begin
      // Cut short; the next file's restart mark discards the rest.
      n = $urandom_range(wav_q.size() - 1, 1);
      while (wav_q.size() > n) void'(wav_q.pop_back());
    end else if (pick < 28) begin
      repeat ($urandom_range(4, 1)) wav_q.push_back(8'($urandom));
    end
    send_file();
  endtask

  // Result side: checks each accepted word and decides ready for the next edge.
  initial begin
    result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.kind = out_ch.kind;
        got.payload_byte = out_ch.payload_byte;
        got.channel_count = out_ch.channel_count;
        got.sample_rate = out_ch.sample_rate;
        got.sample_bits = out_ch.sample_bits;
        got.sample_format = out_ch.sample_format;
        got.data_bytes = out_ch.data_bytes;
        got.error_code = out_ch.error_code;
        got.not_pcm = out_ch.not_pcm;
        got.last = out_ch.last;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int unsigned wait_cycles;
    int unsigned start_count;
    sb = new();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.start_file <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Bytes outside any file are ignored.
    send_byte(8'h00, 0);
    send_byte(8'hFF, 0);
    send_byte(8'h52, 0);

    // Tag mismatches: first and last RIFF character, WAVE, fmt.
    begin_file(16'd1, 16'd1, 32'd8000, 16'd8);
    add_chunk("data", 2, 2);
    wav_q[0] = 8'hFF;
    send_file();
    wav_q[0] = TAG_BYTES[TAG_RIFF][0];
    wav_q[3] = 8'h00;
    send_file();
    wav_q[3] = TAG_BYTES[TAG_RIFF][3];
    wav_q[11] = 8'h00;
    send_file();
    wav_q[11] = TAG_BYTES[TAG_WAVE][3];
    wav_q[15] = 8'h21;
    send_file();

    // All eight sample formats, alternating PCM and non-PCM codes.
    for (int f = 0; f < 8; f++) begin
      begin_file((f % 2 == 0) ? 16'd1 : 16'd3, (f % 2 == 1) ? 16'd2 : 16'd1,
                 32'd44100, 16'(8 << (f / 2)));
      add_chunk("data", 3, 3);
      if (f == 0) wav_q.push_back(8'hAA);  // trailing byte after the last data byte
      send_file();
    end

    // Empty data chunk with extreme format fields; then zero fields, skipped chunks and a short data chunk.
    begin_file(16'hFFFF, 16'd2, 32'hFFFF_FFFF, 16'd64);
    add_chunk("data", 0, 0);
    send_file();
    begin_file(16'h0000, 16'd1, 32'd0, 16'd16);
    add_chunk("LIST", 0, 0);
    add_chunk("datb", 3, 3);
    add_chunk("data", 2, 2);
    send_file();

    // Unsupported depths and channel counts; depth is judged first.
    begin_file(16'd1, 16'd1, 32'd22050, 16'd24);
    add_chunk("data", 4, 4);
    send_file();
    begin_file(16'd1, 16'd0, 32'd22050, 16'd16);
    add_chunk("data", 4, 4);
    send_file();
    begin_file(16'd7, 16'hFFFF, 32'd96000, 16'd8);
    add_chunk("data", 1, 1);
    send_file();
    begin_file(16'd1, 16'd3, 32'd96000, 16'hFFFF);
    add_chunk("data", 1, 1);
    send_file();

    // Huge sizes cut short by a restart: in data, in a skipped chunk, in a tag.
    begin_file(16'd1, 16'd2, 32'd48000, 16'd16);
    add_chunk("data", 32'hFFFF_FFFF, 5);
    send_file();
    begin_file(16'd1, 16'd2, 32'd48000, 16'd16);
    add_chunk("JUNK", 32'hFFFF_FFF0, 6);
    send_file();
    send_byte(8'h52, 1);
    send_byte(8'h49, 0);
    send_byte(8'h00, 1);

    // Receiver holds off while a long file streams in, so the input backs up.
    hold_left = 150;
    begin_file(16'd1, 16'd2, 32'd44100, 16'd16);
    add_chunk("data", 60, 60);
    send_file();

    // Random files fill up the rest of the byte budget in four idling phases.
    start_count = sent_count;
    while (sent_count < ITEM_TARGET) begin
      case (((sent_count - start_count) * 4) / (ITEM_TARGET - start_count))
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 45; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 45; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      random_file();
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    wait_cycles = 10;
    repeat (wait_cycles) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
